>>> design/lfr_pkg.sv
package lfr_pkg;

  // Largest screen side the sequencer supports; wider register values are clamped to it.
  localparam int MAX_SIDE = 2048;
  localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
  localparam int CFG_W    = 12;
  localparam int FIELD_W  = 16;
  localparam int SUM_W    = FIELD_W + 1;
  localparam int BYTE_W   = 8;

  localparam logic [BYTE_W-1:0] CMD_COLUMN   = 8'h2A;
  localparam logic [BYTE_W-1:0] CMD_ROW      = 8'h2B;
  localparam logic [BYTE_W-1:0] CMD_MEMWRITE = 8'h2C;

  localparam logic FUNC_REQUEST = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;

  localparam logic RS_COMMAND = 1'b0;
  localparam logic RS_DATA    = 1'b1;

  typedef enum logic [0:0] {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } reg_idx_t;

  // Bus sequence position, one-hot. Idle means no fill is running.
  typedef enum logic [12:0] {
    ST_IDLE      = 13'h0001,
    ST_COL_CMD   = 13'h0002,
    ST_COL_SH    = 13'h0004,
    ST_COL_SL    = 13'h0008,
    ST_COL_EH    = 13'h0010,
    ST_COL_EL    = 13'h0020,
    ST_ROW_CMD   = 13'h0040,
    ST_ROW_SH    = 13'h0080,
    ST_ROW_SL    = 13'h0100,
    ST_ROW_EH    = 13'h0200,
    ST_ROW_EL    = 13'h0400,
    ST_MEM_CMD   = 13'h0800,
    ST_COLOR     = 13'h1000
  } step_t;

  // A classified word as it travels from the front end to the sequencer.
  typedef struct packed {
    logic                is_tick;
    logic                reject;
    logic [FIELD_W-1:0]  col_start;
    logic [FIELD_W-1:0]  col_end;
    logic [FIELD_W-1:0]  row_start;
    logic [FIELD_W-1:0]  row_end;
    logic [SIDE_W-1:0]   width;
    logic [SIDE_W-1:0]   height;
    logic [FIELD_W-1:0]  color;
  } item_t;

  typedef struct packed {
    logic               accepted;
    logic               write_valid;
    logic               register_select;
    logic [FIELD_W-1:0] bus_word;
    logic               last_write;
    logic               busy_res;
  } result_t;

  function automatic logic [SUM_W-1:0] clamp_side(logic [CFG_W-1:0] v);
    logic [SUM_W-1:0] wide;
    wide = SUM_W'(v);
    return (wide > SUM_W'(MAX_SIDE)) ? SUM_W'(MAX_SIDE) : wide;
  endfunction

endpackage

>>> design/lfr_if.sv
interface lfr_in_if;
  import lfr_pkg::*;
  logic               valid;
  logic               ready;
  logic               func;
  logic [FIELD_W-1:0] rect_x;
  logic [FIELD_W-1:0] rect_y;
  logic [FIELD_W-1:0] rect_width;
  logic [FIELD_W-1:0] rect_height;
  logic [FIELD_W-1:0] fill_color;

  modport source (
    output valid, func, rect_x, rect_y, rect_width, rect_height, fill_color,
    input  ready
  );
  modport sink (
    input  valid, func, rect_x, rect_y, rect_width, rect_height, fill_color,
    output ready
  );
endinterface

interface lfr_out_if;
  import lfr_pkg::*;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic               write_valid;
  logic               register_select;
  logic [FIELD_W-1:0] bus_word;
  logic               last_write;
  logic               busy_res;

  modport source (
    output valid, accepted, write_valid, register_select, bus_word, last_write, busy_res,
    input  ready
  );
  modport sink (
    input  valid, accepted, write_valid, register_select, bus_word, last_write, busy_res,
    output ready
  );
endinterface

>>> design/lcd_parallel_fill_rect_sequencer.sv
// Channel   Direction  Handshake       Payload
// cmd       in         valid / ready   func, rect_x, rect_y, rect_width, rect_height, fill_color
// rsp       out        valid / ready   accepted, write_valid, register_select, bus_word,
//                                      last_write, busy_res
// apb       in         psel / penable  paddr, pwdata, prdata (two 12-bit screen registers)
//
// Every word on cmd gives exactly one word on rsp, in order; while rsp does not stall, one word
// is taken per cycle. A word passes the clip stage, the two-entry queue and the output register.
// The sequencer sets the rate, from its state retiring one queued word per cycle unless stalled.
// Reset is synchronous; it empties the pipeline, idles the sequencer and restores 240 x 320.
// When streaming, the queue holds one word, so a stall on rsp lets cmd take one more word into
// the spare queue entry before cmd.ready drops.
module lcd_parallel_fill_rect_sequencer import lfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  lfr_in_if.sink      cmd,
  lfr_out_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CFG_W-1:0] screen_width;
  logic [CFG_W-1:0] screen_height;
  reg_idx_t         reg_sel;
  logic             q_space;
  logic             push;
  item_t            push_item;
  logic             pop;
  logic             head_valid;
  item_t            head;

  // Registers sit at byte offsets 0 and 4, so address bit 2 picks the register.
  assign reg_sel = reg_idx_t'(paddr[2]);
  assign pready  = 1'b1;

  always_comb begin
    unique case (reg_sel)
      REG_SCREEN_WIDTH:  prdata = 32'(screen_width);
      REG_SCREEN_HEIGHT: prdata = 32'(screen_height);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= CFG_W'(240);
      screen_height <= CFG_W'(320);
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_SCREEN_WIDTH:  screen_width  <= pwdata[CFG_W-1:0];
        REG_SCREEN_HEIGHT: screen_height <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // The front end checks and clips each request against the screen size.
  lfr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .q_space       (q_space),
    .push          (push),
    .push_item     (push_item)
  );

  // The queue lets the front end keep accepting while the output is stalled.
  lfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .space      (q_space),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // The sequencer holds the fill state and plays out the bus writes.
  lfr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (head_valid),
    .q_item  (head),
    .pop     (pop),
    .rsp     (rsp)
  );

  // The final color word is a data write and ends the fill.
  a_last_ends_fill: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.last_write |-> rsp.write_valid && rsp.register_select && !rsp.busy_res)
    else $error("last color word does not close the fill");

  // A taken request never carries a bus write and always starts a fill.
  a_accept_starts_fill: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.accepted |-> !rsp.write_valid && rsp.busy_res)
    else $error("accepted request without a running fill");

  // Words without a bus write carry an all-zero bus payload.
  a_idle_word_clear: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.write_valid |->
      rsp.bus_word == '0 && !rsp.register_select && !rsp.last_write)
    else $error("bus payload set on a word without a write");

  // A fill only ends with its last color word or stays running.
  a_busy_drop: assert property (@(posedge clk) disable iff (rst)
    $past(rsp.valid && rsp.ready && rsp.busy_res) && rsp.valid && rsp.write_valid
      |-> rsp.busy_res || rsp.last_write)
    else $error("fill ended without a last color word");

endmodule

>>> design/lfr_front.sv
module lfr_front import lfr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  lfr_in_if.sink           cmd,
  input  logic [CFG_W-1:0] screen_width,
  input  logic [CFG_W-1:0] screen_height,
  input  logic             q_space,
  output logic             push,
  output item_t            push_item
);

  logic             f_valid;
  item_t            f_item;
  item_t            item_next;
  logic [SUM_W-1:0] sw;
  logic [SUM_W-1:0] sh;
  logic [SUM_W-1:0] x;
  logic [SUM_W-1:0] y;
  logic [SUM_W-1:0] x_end;
  logic [SUM_W-1:0] y_end;
  logic [SUM_W-1:0] x_lim;
  logic [SUM_W-1:0] y_lim;

  assign cmd.ready = !f_valid || q_space;
  assign push      = f_valid && q_space;
  assign push_item = f_item;

  // Clip the rectangle to the screen: the far edge is the smaller of the
  // requested edge and the screen edge.
  always_comb begin
    sw    = clamp_side(screen_width);
    sh    = clamp_side(screen_height);
    x     = SUM_W'(cmd.rect_x);
    y     = SUM_W'(cmd.rect_y);
    x_end = x + SUM_W'(cmd.rect_width);
    y_end = y + SUM_W'(cmd.rect_height);
    x_lim = (x_end > sw) ? sw : x_end;
    y_lim = (y_end > sh) ? sh : y_end;

    item_next.is_tick   = (cmd.func == FUNC_TICK);
    item_next.reject    = (cmd.rect_width == '0) || (cmd.rect_height == '0) ||
                          (x >= sw) || (y >= sh);
    item_next.col_start = cmd.rect_x;
    item_next.col_end   = FIELD_W'(x_lim - SUM_W'(1));
    item_next.row_start = cmd.rect_y;
    item_next.row_end   = FIELD_W'(y_lim - SUM_W'(1));
    item_next.width     = SIDE_W'(x_lim - x);
    item_next.height    = SIDE_W'(y_lim - y);
    item_next.color     = cmd.fill_color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (cmd.ready) begin
      f_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      f_item <= item_next;
    end
  end

endmodule

>>> design/lfr_queue.sv
module lfr_queue import lfr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  space,
  input  logic  pop,
  output logic  head_valid,
  output item_t head
);

  item_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign space      = (count != 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

>>> design/lfr_back.sv
module lfr_back import lfr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   q_valid,
  input  item_t  q_item,
  output logic   pop,
  lfr_out_if.source rsp
);

  step_t              state;
  step_t              state_next;
  logic [FIELD_W-1:0] col_start;
  logic [FIELD_W-1:0] col_end;
  logic [FIELD_W-1:0] row_start;
  logic [FIELD_W-1:0] row_end;
  logic [FIELD_W-1:0] held_color;
  logic [SIDE_W-1:0]  width;
  logic [SIDE_W-1:0]  col_left;
  logic [SIDE_W-1:0]  col_left_next;
  logic [SIDE_W-1:0]  row_left;
  logic [SIDE_W-1:0]  row_left_next;
  logic               load;
  logic               out_valid;
  result_t            out_data;
  result_t            res;

  assign pop = q_valid && (!out_valid || rsp.ready);

  always_comb begin
    res           = '0;
    state_next    = state;
    col_left_next = col_left;
    row_left_next = row_left;
    load          = 1'b0;
    if (!q_item.is_tick) begin
      if (state == ST_IDLE && !q_item.reject) begin
        load          = 1'b1;
        res.accepted  = 1'b1;
        state_next    = ST_COL_CMD;
        col_left_next = q_item.width;
        row_left_next = q_item.height;
      end
    end else if (state != ST_IDLE) begin
      res.write_valid     = 1'b1;
      res.register_select = RS_DATA;
      unique case (state)
        ST_COL_CMD: begin
          res.register_select = RS_COMMAND;
          res.bus_word        = FIELD_W'(CMD_COLUMN);
          state_next          = ST_COL_SH;
        end
        ST_COL_SH: begin
          res.bus_word = FIELD_W'(col_start[FIELD_W-1:BYTE_W]);
          state_next   = ST_COL_SL;
        end
        ST_COL_SL: begin
          res.bus_word = FIELD_W'(col_start[BYTE_W-1:0]);
          state_next   = ST_COL_EH;
        end
        ST_COL_EH: begin
          res.bus_word = FIELD_W'(col_end[FIELD_W-1:BYTE_W]);
          state_next   = ST_COL_EL;
        end
        ST_COL_EL: begin
          res.bus_word = FIELD_W'(col_end[BYTE_W-1:0]);
          state_next   = ST_ROW_CMD;
        end
        ST_ROW_CMD: begin
          res.register_select = RS_COMMAND;
          res.bus_word        = FIELD_W'(CMD_ROW);
          state_next          = ST_ROW_SH;
        end
        ST_ROW_SH: begin
          res.bus_word = FIELD_W'(row_start[FIELD_W-1:BYTE_W]);
          state_next   = ST_ROW_SL;
        end
        ST_ROW_SL: begin
          res.bus_word = FIELD_W'(row_start[BYTE_W-1:0]);
          state_next   = ST_ROW_EH;
        end
        ST_ROW_EH: begin
          res.bus_word = FIELD_W'(row_end[FIELD_W-1:BYTE_W]);
          state_next   = ST_ROW_EL;
        end
        ST_ROW_EL: begin
          res.bus_word = FIELD_W'(row_end[BYTE_W-1:0]);
          state_next   = ST_MEM_CMD;
        end
        ST_MEM_CMD: begin
          res.register_select = RS_COMMAND;
          res.bus_word        = FIELD_W'(CMD_MEMWRITE);
          state_next          = ST_COLOR;
        end
        ST_COLOR: begin
          // Pixels are counted as columns within rows, so no product is needed.
          res.bus_word = held_color;
          if (col_left == SIDE_W'(1)) begin
            col_left_next = width;
            row_left_next = row_left - SIDE_W'(1);
            if (row_left == SIDE_W'(1)) begin
              res.last_write = 1'b1;
              state_next     = ST_IDLE;
            end
          end else begin
            col_left_next = col_left - SIDE_W'(1);
          end
        end
        default: begin
          state_next = ST_IDLE;
        end
      endcase
    end
    res.busy_res = (state_next != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= res;
      col_left <= col_left_next;
      row_left <= row_left_next;
    end
    if (pop && load) begin
      col_start  <= q_item.col_start;
      col_end    <= q_item.col_end;
      row_start  <= q_item.row_start;
      row_end    <= q_item.row_end;
      held_color <= q_item.color;
      width      <= q_item.width;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.accepted        = out_data.accepted;
  assign rsp.write_valid     = out_data.write_valid;
  assign rsp.register_select = out_data.register_select;
  assign rsp.bus_word        = out_data.bus_word;
  assign rsp.last_write      = out_data.last_write;
  assign rsp.busy_res        = out_data.busy_res;

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
  import lfr_pkg::*;

  // The longest quiet stretch in a correct run is the deliberate response hold below,
  // plus a drain and two register writes; the watchdog allows ten times the hold itself.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int NUM_PHASES     = 12;
  localparam int PHASE_WORDS    = 150;
  // Random requests are shaped so that no fill paints more than this many pixels.
  localparam int MAX_AREA       = 64;
  localparam int MAX_PRINTS     = 100;

  // Where the sequencer stands within one fill, counted in bus writes.
  typedef enum logic [3:0] {
    POS_COL_CMD, POS_COL_SH, POS_COL_SL, POS_COL_EH, POS_COL_EL,
    POS_ROW_CMD, POS_ROW_SH, POS_ROW_SL, POS_ROW_EH, POS_ROW_EL,
    POS_MEM_CMD, POS_COLOR
  } seq_pos_t;

  typedef struct packed {
    logic               func;
    logic [FIELD_W-1:0] rect_x;
    logic [FIELD_W-1:0] rect_y;
    logic [FIELD_W-1:0] rect_width;
    logic [FIELD_W-1:0] rect_height;
    logic [FIELD_W-1:0] fill_color;
  } cmd_word_t;

  // One row of the directed table: a command word, how many times it is sent, and,
  // where the answer is obvious, the response word typed in by hand.
  typedef struct packed {
    cmd_word_t  w;
    logic [4:0] reps;
    logic       typed;
    result_t    want;
  } dir_row_t;

  localparam result_t RES_QUIET = '0;
  localparam result_t RES_BUSY = '{accepted: 1'b0, write_valid: 1'b0,
    register_select: 1'b0, bus_word: '0, last_write: 1'b0, busy_res: 1'b1};
  localparam result_t RES_TAKEN = '{accepted: 1'b1, write_valid: 1'b0,
    register_select: 1'b0, bus_word: '0, last_write: 1'b0, busy_res: 1'b1};
  localparam result_t RES_COL_CMD = '{accepted: 1'b0, write_valid: 1'b1,
    register_select: RS_COMMAND, bus_word: {8'h00, CMD_COLUMN}, last_write: 1'b0,
    busy_res: 1'b1};
  localparam result_t RES_LAST_WHITE = '{accepted: 1'b0, write_valid: 1'b1,
    register_select: RS_DATA, bus_word: 16'hFFFF, last_write: 1'b1, busy_res: 1'b0};

  // Directed part, run at the reset screen size of 240 x 320. The clipped request
  // sits on the bottom-right pixel, so it plays out as eleven header writes and a
  // single color word.
  localparam dir_row_t DIR_TAB [13] = '{
    // Tick straight after reset: nothing is running.
    '{'{FUNC_TICK, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 5'd1, 1'b1, RES_QUIET},
    // Zero width and zero height are refused.
    '{'{FUNC_REQUEST, 16'd0, 16'd0, 16'd0, 16'd5, 16'h1234}, 5'd1, 1'b1, RES_QUIET},
    '{'{FUNC_REQUEST, 16'd0, 16'd0, 16'd5, 16'd0, 16'h1234}, 5'd1, 1'b1, RES_QUIET},
    // Origin on the right edge or the bottom edge is off screen.
    '{'{FUNC_REQUEST, 16'd240, 16'd0, 16'd1, 16'd1, 16'h0}, 5'd1, 1'b1, RES_QUIET},
    '{'{FUNC_REQUEST, 16'd0, 16'd320, 16'd1, 16'd1, 16'h0}, 5'd1, 1'b1, RES_QUIET},
    '{'{FUNC_REQUEST, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 5'd1, 1'b1,
      RES_QUIET},
    // Largest size at the last pixel is clipped down to one pixel and taken.
    '{'{FUNC_REQUEST, 16'd239, 16'd319, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 5'd1, 1'b1,
      RES_TAKEN},
    // A request while that fill runs is refused and reports busy.
    '{'{FUNC_REQUEST, 16'd0, 16'd0, 16'd1, 16'd1, 16'h0}, 5'd1, 1'b1, RES_BUSY},
    '{'{FUNC_TICK, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 5'd1, 1'b1, RES_COL_CMD},
    '{'{FUNC_TICK, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 5'd10, 1'b0, RES_QUIET},
    '{'{FUNC_TICK, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 5'd1, 1'b1, RES_LAST_WHITE},
    // Ticks once the fill is over give an all-zero word.
    '{'{FUNC_TICK, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 5'd1, 1'b1, RES_QUIET},
    '{'{FUNC_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 5'd1, 1'b1,
      RES_QUIET}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lfr_in_if  cmd_ch ();
  lfr_out_if rsp_ch ();

  lcd_parallel_fill_rect_sequencer u_top (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // The testbench's own view of the block: screen registers and fill state.
  logic [CFG_W-1:0]   scr_w;
  logic [CFG_W-1:0]   scr_h;
  logic               fill_active;
  seq_pos_t           seq_pos;
  logic [FIELD_W-1:0] col_lo;
  logic [FIELD_W-1:0] col_hi;
  logic [FIELD_W-1:0] row_lo;
  logic [FIELD_W-1:0] row_hi;
  logic [FIELD_W-1:0] fill_rgb;
  logic [31:0]        px_left;

  // Response words still owed by the block, oldest first.
  result_t pending_bus_words [$];

  int unsigned words_sent    = 0;
  int unsigned words_checked = 0;
  int unsigned fills_done    = 0;
  int unsigned settings_used = 0;
  int unsigned err_count     = 0;
  int unsigned quiet_cycles  = 0;
  bit          quiet_tail    = 1'b0;
  bit          hold_rsp      = 1'b0;

  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("tb: MISMATCH %s", msg);
  endtask

  task automatic check_field(string name, logic [FIELD_W-1:0] got,
                             logic [FIELD_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("response word %0d, %s: got %h, want %h",
                                words_checked, name, got, want));
    end
  endtask

  // Usable screen side: register values above the largest side are clamped to it.
  function automatic int unsigned side_px(logic [CFG_W-1:0] v);
    return (32'(v) > MAX_SIDE) ? MAX_SIDE : 32'(v);
  endfunction

  // Pixel count of a request after clipping, or zero where it is refused.
  function automatic int unsigned clipped_area(cmd_word_t c, output int unsigned cw,
                                               output int unsigned ch);
    int unsigned sw;
    int unsigned sh;
    sw = side_px(scr_w);
    sh = side_px(scr_h);
    cw = 32'(c.rect_width);
    ch = 32'(c.rect_height);
    if (cw == 0 || ch == 0 || 32'(c.rect_x) >= sw || 32'(c.rect_y) >= sh) return 0;
    if (32'(c.rect_x) + cw > sw) cw = sw - 32'(c.rect_x);
    if (32'(c.rect_y) + ch > sh) ch = sh - 32'(c.rect_y);
    return cw * ch;
  endfunction

  // Works out the response to one accepted command word and advances the fill state.
  function automatic result_t next_bus_result(cmd_word_t c);
    result_t     r;
    int unsigned cw;
    int unsigned ch;
    int unsigned area;
    r = RES_QUIET;
    if (c.func == FUNC_REQUEST) begin
      if (fill_active) begin
        // A running fill is never disturbed by a new request.
        r.busy_res = 1'b1;
      end else begin
        area = clipped_area(c, cw, ch);
        if (area != 0) begin
          col_lo      = c.rect_x;
          col_hi      = FIELD_W'(32'(c.rect_x) + cw - 1);
          row_lo      = c.rect_y;
          row_hi      = FIELD_W'(32'(c.rect_y) + ch - 1);
          fill_rgb    = c.fill_color;
          px_left     = area;
          seq_pos     = POS_COL_CMD;
          fill_active = 1'b1;
          r.accepted  = 1'b1;
          r.busy_res  = 1'b1;
        end
      end
    end else if (fill_active) begin
      r.write_valid     = 1'b1;
      r.register_select = RS_DATA;
      case (seq_pos)
        POS_COL_CMD: begin
          r.register_select = RS_COMMAND;
          r.bus_word        = {8'h00, CMD_COLUMN};
        end
        POS_COL_SH: r.bus_word = {8'h00, col_lo[15:8]};
        POS_COL_SL: r.bus_word = {8'h00, col_lo[7:0]};
        POS_COL_EH: r.bus_word = {8'h00, col_hi[15:8]};
        POS_COL_EL: r.bus_word = {8'h00, col_hi[7:0]};
        POS_ROW_CMD: begin
          r.register_select = RS_COMMAND;
          r.bus_word        = {8'h00, CMD_ROW};
        end
        POS_ROW_SH: r.bus_word = {8'h00, row_lo[15:8]};
        POS_ROW_SL: r.bus_word = {8'h00, row_lo[7:0]};
        POS_ROW_EH: r.bus_word = {8'h00, row_hi[15:8]};
        POS_ROW_EL: r.bus_word = {8'h00, row_hi[7:0]};
        POS_MEM_CMD: begin
          r.register_select = RS_COMMAND;
          r.bus_word        = {8'h00, CMD_MEMWRITE};
        end
        default: begin
          r.bus_word = fill_rgb;
          if (px_left != 0) px_left--;
          if (px_left == 0) begin
            r.last_write = 1'b1;
            fill_active  = 1'b0;
            seq_pos      = POS_COL_CMD;
          end
        end
      endcase
      if (seq_pos != POS_COLOR && fill_active) seq_pos = seq_pos.next();
      r.busy_res = fill_active;
    end
    return r;
  endfunction

  function automatic cmd_word_t random_word(logic func);
    cmd_word_t w;
    w.func        = func;
    w.rect_x      = FIELD_W'($urandom);
    w.rect_y      = FIELD_W'($urandom);
    w.rect_width  = FIELD_W'($urandom);
    w.rect_height = FIELD_W'($urandom);
    w.fill_color  = FIELD_W'($urandom);
    return w;
  endfunction

  // Offers one command word, sometimes after an idle burst, and records what the
  // block owes for it once it is taken.
  task automatic push_word(cmd_word_t w, bit typed = 1'b0, result_t want = RES_QUIET);
    result_t got;
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.func        <= w.func;
    cmd_ch.rect_x      <= w.rect_x;
    cmd_ch.rect_y      <= w.rect_y;
    cmd_ch.rect_width  <= w.rect_width;
    cmd_ch.rect_height <= w.rect_height;
    cmd_ch.fill_color  <= w.fill_color;
    do @(posedge clk); while (!cmd_ch.ready);
    got = next_bus_result(w);
    pending_bus_words.push_back(typed ? want : got);
    words_sent++;
  endtask

  // Stops offering words and waits until every owed response has come back.
  task automatic drain_block(int settle);
    cmd_ch.valid <= 1'b0;
    while (pending_bus_words.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // APB write followed by a read back of the same register.
  task automatic write_screen_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_SCREEN_WIDTH) scr_w = val;
    else scr_h = val;
    if (rd !== 32'(val)) begin
      report_mismatch($sformatf("register %s read back %h, want %h", idx.name(), rd, val));
    end
  endtask

  // Response checker: every word taken from the block is held against the oldest
  // expectation, field by field.
  always @(posedge clk) begin : bus_check
    result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_bus_words.size() == 0) begin
        report_mismatch($sformatf("response word %0d arrived with nothing expected",
                                  words_checked));
      end else begin
        want = pending_bus_words.pop_front();
        check_field("accepted", FIELD_W'(rsp_ch.accepted), FIELD_W'(want.accepted));
        check_field("write_valid", FIELD_W'(rsp_ch.write_valid),
                    FIELD_W'(want.write_valid));
        check_field("register_select", FIELD_W'(rsp_ch.register_select),
                    FIELD_W'(want.register_select));
        check_field("bus_word", rsp_ch.bus_word, want.bus_word);
        check_field("last_write", FIELD_W'(rsp_ch.last_write), FIELD_W'(want.last_write));
        check_field("busy_res", FIELD_W'(rsp_ch.busy_res), FIELD_W'(want.busy_res));
        if (want.last_write) fills_done++;
      end
      words_checked++;
    end
  end

  // Response side back pressure. Mostly ready, with random stalls, and once a long hold so
  // that the two-entry queue fills and the command side stalls.
  // In the last phase the response side never stalls.
  initial begin
    forever begin
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  // Counts cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("tb: watchdog expired after %0d quiet cycles", quiet_cycles);
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    cmd_word_t        w;
    int unsigned      sw_e;
    int unsigned      sh_e;
    int unsigned      n;
    int unsigned      cw;
    int unsigned      ch;
    int unsigned      start;
    int unsigned      pick;
    logic [CFG_W-1:0] nw;
    logic [CFG_W-1:0] nh;

    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    cmd_ch.valid       <= 1'b0;
    cmd_ch.func        <= FUNC_TICK;
    cmd_ch.rect_x      <= '0;
    cmd_ch.rect_y      <= '0;
    cmd_ch.rect_width  <= '0;
    cmd_ch.rect_height <= '0;
    cmd_ch.fill_color  <= '0;
    scr_w       = 12'd240;
    scr_h       = 12'd320;
    fill_active = 1'b0;
    seq_pos     = POS_COL_CMD;
    col_lo      = '0;
    col_hi      = '0;
    row_lo      = '0;
    row_hi      = '0;
    fill_rgb    = '0;
    px_left     = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (DIR_TAB[i]) begin
      repeat (DIR_TAB[i].reps) push_word(DIR_TAB[i].w, DIR_TAB[i].typed, DIR_TAB[i].want);
    end

    // Random phases, each at its own screen size. The first ones hit the register
    // extremes: a one-pixel screen, a zero register that refuses everything, and
    // values beyond the largest side that get clamped.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_block(4);
      case (ph)
        0: begin nw = 12'd1;    nh = 12'd1;    end
        1: begin nw = 12'd0;    nh = 12'd7;    end
        2: begin nw = 12'd4095; nh = 12'd4095; end
        3: begin nw = 12'd2048; nh = 12'd1;    end
        4: begin nw = 12'd9;    nh = 12'd0;    end
        5: begin nw = 12'd17;   nh = 12'd9;    end
        NUM_PHASES - 1: begin nw = 12'd240; nh = 12'd320; end
        default: begin
          nw = CFG_W'($urandom_range(1, 48));
          nh = CFG_W'($urandom_range(1, 48));
          if ($urandom_range(0, 3) == 0) nw = 12'd4095;
          if ($urandom_range(0, 3) == 0) nh = 12'd2047;
        end
      endcase
      write_screen_reg(REG_SCREEN_WIDTH, nw);
      write_screen_reg(REG_SCREEN_HEIGHT, nh);
      settings_used++;
      sw_e = side_px(scr_w);
      sh_e = side_px(scr_h);
      quiet_tail = (ph == NUM_PHASES - 1);
      if (ph == 6) hold_rsp = 1'b1;
      start = words_sent;
      while (words_sent - start < PHASE_WORDS) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          // A whole fill: a request whose sides are either small or run past the
          // screen edge from near it, then exactly the ticks it needs, with the odd
          // request thrown in while it runs. Now and then the ticks stop early.
          w = random_word(FUNC_REQUEST);
          if (sw_e != 0) begin
            if ($urandom_range(0, 2) == 0) begin
              w.rect_x = FIELD_W'(sw_e - 1 - $urandom_range(0, (sw_e > 8) ? 7 : sw_e - 1));
            end else begin
              w.rect_x     = FIELD_W'($urandom_range(0, sw_e - 1));
              w.rect_width = FIELD_W'($urandom_range(1, 6));
            end
          end
          if (sh_e != 0) begin
            if ($urandom_range(0, 2) == 0) begin
              w.rect_y = FIELD_W'(sh_e - 1 - $urandom_range(0, (sh_e > 8) ? 7 : sh_e - 1));
            end else begin
              w.rect_y      = FIELD_W'($urandom_range(0, sh_e - 1));
              w.rect_height = FIELD_W'($urandom_range(1, 6));
            end
          end
          if (w.rect_width == 0) w.rect_width = 16'd1;
          if (w.rect_height == 0) w.rect_height = 16'd1;
          push_word(w);
          n = fill_active ? 32'(POS_COLOR - seq_pos) + px_left : 0;
          if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n);
          for (int unsigned k = 0; k < n; k++) begin
            if (fill_active && $urandom_range(0, 19) == 0) push_word(random_word(FUNC_REQUEST));
            push_word(random_word(FUNC_TICK));
          end
        end else if (pick < 85) begin
          // Noise, kept clear of fills too large to finish quickly.
          w = random_word(1'($urandom_range(0, 1)));
          if (w.func == FUNC_REQUEST && !fill_active && clipped_area(w, cw, ch) > MAX_AREA) begin
            w.rect_height = '0;
          end
          push_word(w);
        end else begin
          repeat ($urandom_range(1, 5)) push_word(random_word(FUNC_TICK));
        end
      end
      // Let a fill that was cut short run to its end before the screen size changes.
      while (fill_active) push_word(random_word(FUNC_TICK));
    end

    drain_block(8);
    $display("tb: %0d command words over %0d screen sizes, %0d fills played to the end",
             words_sent, settings_used, fills_done);
    $display("tb: %0d response words checked, %0d mismatches", words_checked, err_count);
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
design/lfr_pkg.sv
design/lfr_if.sv
design/lfr_front.sv
design/lfr_queue.sv
design/lfr_back.sv
design/lcd_parallel_fill_rect_sequencer.sv
test/tb.sv
